// ----- design/fftm_pkg.sv -----
// shared constants, types, twiddle tables and helpers of the fft magnitude unit
package fftm_pkg;

  localparam int POINTS    = 512;
  localparam int LOG2_PTS  = $clog2(POINTS);
  localparam int ADDR_W    = LOG2_PTS;
  localparam int HALF      = POINTS / 2;
  localparam int TW_IDX_W  = LOG2_PTS - 1;
  localparam int STG_W     = $clog2(LOG2_PTS);
  localparam int TW_BITS   = 16;
  localparam int FRAC      = TW_BITS - 1;
  localparam int SAMPLE_W  = 16;
  localparam int BIN_W     = 9;
  localparam int MAG_W     = 25;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = TW_BITS + DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int SQ_W      = 2 * DATA_W;
  localparam int ROOT_W    = DATA_W;
  localparam int SERIES_TERMS = 12;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef logic [HALF-1:0][TW_BITS-1:0] rom_t;

  typedef enum logic [2:0] {
    WOP_NONE,
    WOP_LOAD,
    WOP_A_SWAP,
    WOP_B_SWAP,
    WOP_A_SUM,
    WOP_B_DIF
  } wop_t;

  typedef struct packed {
    wop_t                wop;
    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [TW_IDX_W-1:0] tw_idx;
    logic                rd_en;
    logic                mul_en;
    logic                add_en;
    logic                sq_en;
    logic                sqrt_start;
    logic                mag_we;
    logic                mag_rd;
    logic                out_load;
    logic                have_result;
  } fftm_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic out_free;
  } fftm_sts_t;

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = a[ADDR_W-1-i];
    end
    return r;
  endfunction

  // shift-subtract long division for the elaboration-time series terms
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // elaboration-time twiddle table from a q30 taylor series
  function automatic rom_t build_rom(input logic want_sin);
    rom_t              rom;
    longint unsigned   num, x, x2, ct, st, mag, r, lim;
    longint            csum, ssum, v;
    logic              flip;
    lim = (64'd1 << FRAC) - 64'd1;
    for (int t = 0; t < HALF; t++) begin
      flip = (4 * t > POINTS);
      num  = flip ? longint'(POINTS - 2 * t) : longint'(2 * t);
      x    = (PI_Q30 * num) >> LOG2_PTS;
      x2   = (x * x) >> 30;
      ct   = 64'd1 << 30;
      st   = x;
      csum = longint'(ct);
      ssum = longint'(st);
      for (int k = 1; k <= SERIES_TERMS; k++) begin
        ct = div_u64((ct * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
        st = div_u64((st * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
        if ((k & 1) == 1) begin
          csum = csum - longint'(ct);
          ssum = ssum - longint'(st);
        end else begin
          csum = csum + longint'(ct);
          ssum = ssum + longint'(st);
        end
      end
      v   = want_sin ? ssum : (flip ? -csum : csum);
      mag = longint'(v < 0 ? -v : v);
      r   = ((mag << FRAC) + (64'd1 << 29)) >> 30;
      if (r > lim) begin
        r = lim;
      end
      rom[t] = (v < 0) ? TW_BITS'(-longint'(r)) : TW_BITS'(r);
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_rom(1'b0);
  localparam rom_t SIN_ROM = build_rom(1'b1);

endpackage

// ----- design/fftm_if.sv -----
// valid/ready channel interfaces for the sample/read input and the magnitude output
interface fftm_in_if;
  import fftm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] sample;
  logic [BIN_W-1:0]           bin;
  modport source (output valid, action, sample, bin, input ready);
  modport sink (input valid, action, sample, bin, output ready);
endinterface

interface fftm_out_if;
  import fftm_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             ready_res;
  modport source (output valid, magnitude, ready_res, input ready);
  modport sink (input valid, magnitude, ready_res, output ready);
endinterface

// ----- design/fftm_isqrt.sv -----
// iterative integer square root, one root bit per cycle
module fftm_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fftm_pkg::SQ_W-1:0]  radicand,
  output logic                       done,
  output logic [fftm_pkg::ROOT_W-1:0] root
);
  import fftm_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  assign rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(ROOT_W - 1);
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r  <= cnt_r - 1'b1;
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- design/fftm_datapath.sv -----
// sample store, butterfly arithmetic, magnitude store and output register
module fftm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fftm_pkg::fftm_cmd_t                 cmd,
  output fftm_pkg::fftm_sts_t                 sts,
  input  logic signed [fftm_pkg::SAMPLE_W-1:0] sample,
  input  logic [fftm_pkg::BIN_W-1:0]          bin,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [fftm_pkg::MAG_W-1:0]          magnitude,
  output logic                                ready_res
);
  import fftm_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC - 1);
  localparam logic [ROOT_W-1:0]       MAG_MAX  = ROOT_W'((64'd1 << MAG_W) - 64'd1);

  logic [2*DATA_W-1:0] mem [POINTS];
  logic [MAG_W-1:0]    mag_mem [POINTS];

  logic [2*DATA_W-1:0]        rd_a_r, rd_b_r;
  logic signed [TW_BITS-1:0]  tw_c_r, tw_s_r;
  logic signed [PROD_W-1:0]   p_cr_r, p_si_r, p_ci_r, p_sr_r;
  logic signed [DATA_W-1:0]   tr_r, ti_r;
  logic [SQ_W-1:0]            sq_re_r, sq_im_r;
  logic [MAG_W-1:0]           mag_rd_r;
  logic                       out_valid_r;
  logic [MAG_W-1:0]           out_mag_r;
  logic                       out_rdy_r;

  logic signed [DATA_W-1:0] ur, ui, br, bi;
  logic signed [SUM_W-1:0]  t_re, t_im;
  logic [DATA_W-1:0]        abs_re, abs_im;
  logic                     we;
  logic [ADDR_W-1:0]        wa;
  logic [2*DATA_W-1:0]      wd;
  logic                     sqrt_done;
  logic [ROOT_W-1:0]        root;

  assign ur = rd_a_r[2*DATA_W-1:DATA_W];
  assign ui = rd_a_r[DATA_W-1:0];
  assign br = rd_b_r[2*DATA_W-1:DATA_W];
  assign bi = rd_b_r[DATA_W-1:0];

  assign t_re = (SUM_W'(p_cr_r) + SUM_W'(p_si_r) + HALF_LSB) >>> FRAC;
  assign t_im = (SUM_W'(p_ci_r) - SUM_W'(p_sr_r) + HALF_LSB) >>> FRAC;

  assign abs_re = ur[DATA_W-1] ? DATA_W'(-ur) : DATA_W'(ur);
  assign abs_im = ui[DATA_W-1] ? DATA_W'(-ui) : DATA_W'(ui);

  always_comb begin
    we = 1'b1;
    wa = cmd.addr_a;
    wd = rd_b_r;
    case (cmd.wop)
      WOP_LOAD:   wd = {DATA_W'(sample), {DATA_W{1'b0}}};
      WOP_A_SWAP: wd = rd_b_r;
      WOP_B_SWAP: begin
        wa = cmd.addr_b;
        wd = rd_a_r;
      end
      WOP_A_SUM:  wd = {DATA_W'(ur + tr_r), DATA_W'(ui + ti_r)};
      WOP_B_DIF: begin
        wa = cmd.addr_b;
        wd = {DATA_W'(ur - tr_r), DATA_W'(ui - ti_r)};
      end
      default:    we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[cmd.addr_a];
      rd_b_r <= mem[cmd.addr_b];
      tw_c_r <= $signed(COS_ROM[cmd.tw_idx]);
      tw_s_r <= $signed(SIN_ROM[cmd.tw_idx]);
    end
    if (cmd.mul_en) begin
      p_cr_r <= tw_c_r * br;
      p_si_r <= tw_s_r * bi;
      p_ci_r <= tw_c_r * bi;
      p_sr_r <= tw_s_r * br;
    end
    if (cmd.add_en) begin
      tr_r <= DATA_W'(t_re);
      ti_r <= DATA_W'(t_im);
    end
    if (cmd.sq_en) begin
      sq_re_r <= abs_re * abs_re;
      sq_im_r <= abs_im * abs_im;
    end
    if (cmd.mag_we) begin
      mag_mem[cmd.addr_a] <= (root > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : root[MAG_W-1:0];
    end
    if (cmd.mag_rd) begin
      mag_rd_r <= mag_mem[ADDR_W'(bin)];
    end
  end

  fftm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_re_r + sq_im_r),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mag_r <= cmd.have_result ? mag_rd_r : '0;
      out_rdy_r <= cmd.have_result;
    end
  end

  assign sts.sqrt_done = sqrt_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign magnitude = out_mag_r;
  assign ready_res = out_rdy_r;

endmodule

// ----- design/fftm_ctrl.sv -----
// sequencer for loading, bit reversal, butterfly passes, magnitudes and reads
module fftm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  input  fftm_pkg::fftm_sts_t sts,
  output fftm_pkg::fftm_cmd_t cmd
);
  import fftm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BR,
    ST_BR_WA,
    ST_BR_WB,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WA,
    ST_BF_WB,
    ST_MG_RD,
    ST_MG_SQ,
    ST_MG_ST,
    ST_MG_WT,
    ST_RD_WT,
    ST_RD_OUT
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   load_cnt_r;
  logic [ADDR_W-1:0]   idx_r;
  logic [TW_IDX_W-1:0] n_r;
  logic [STG_W-1:0]    stage_r;
  logic                have_res_r;

  logic [ADDR_W-1:0]   rev_idx;
  logic                do_swap;
  logic [ADDR_W-1:0]   n_ext, mask, j_idx, i1, i2;
  logic                idx_last;

  assign rev_idx  = bit_rev(idx_r);
  assign do_swap  = (rev_idx > idx_r);
  assign idx_last = &idx_r;

  // butterfly addresses of pair n within the current stage
  assign n_ext = ADDR_W'(n_r);
  assign mask  = (ADDR_W'(1) << stage_r) - ADDR_W'(1);
  assign j_idx = n_ext & mask;
  assign i1    = ((n_ext & ~mask) << 1) | j_idx;
  assign i2    = i1 | (mask + ADDR_W'(1));

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.wop         = WOP_NONE;
    cmd.addr_a      = idx_r;
    cmd.addr_b      = rev_idx;
    cmd.tw_idx      = TW_IDX_W'(j_idx << (STG_W'(LOG2_PTS - 1) - stage_r));
    cmd.have_result = have_res_r;
    case (state_r)
      ST_IDLE: begin
        cmd.addr_a = load_cnt_r;
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.wop = WOP_LOAD;
          end else begin
            cmd.mag_rd = 1'b1;
          end
        end
      end
      ST_BR:     cmd.rd_en = do_swap;
      ST_BR_WA:  cmd.wop = WOP_A_SWAP;
      ST_BR_WB:  cmd.wop = WOP_B_SWAP;
      ST_BF_RD: begin
        cmd.addr_a = i1;
        cmd.addr_b = i2;
        cmd.rd_en  = 1'b1;
      end
      ST_BF_MUL: cmd.mul_en = 1'b1;
      ST_BF_ADD: cmd.add_en = 1'b1;
      ST_BF_WA: begin
        cmd.addr_a = i1;
        cmd.wop    = WOP_A_SUM;
      end
      ST_BF_WB: begin
        cmd.addr_b = i2;
        cmd.wop    = WOP_B_DIF;
      end
      ST_MG_RD:  cmd.rd_en = 1'b1;
      ST_MG_SQ:  cmd.sq_en = 1'b1;
      ST_MG_ST:  cmd.sqrt_start = 1'b1;
      ST_MG_WT:  cmd.mag_we = sts.sqrt_done;
      ST_RD_WT:  cmd.out_load = 1'b0;
      ST_RD_OUT: cmd.out_load = sts.out_free;
      default:   cmd.wop = WOP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      idx_r      <= '0;
      n_r        <= '0;
      stage_r    <= '0;
      have_res_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_action == ACT_LOAD) begin
              load_cnt_r <= load_cnt_r + 1'b1;
              if (&load_cnt_r) begin
                idx_r   <= '0;
                state_r <= ST_BR;
              end
            end else begin
              state_r <= ST_RD_WT;
            end
          end
        end
        ST_BR: begin
          if (do_swap) begin
            state_r <= ST_BR_WA;
          end else begin
            idx_r <= idx_r + 1'b1;
            if (idx_last) begin
              n_r     <= '0;
              stage_r <= '0;
              state_r <= ST_BF_RD;
            end
          end
        end
        ST_BR_WA: state_r <= ST_BR_WB;
        ST_BR_WB: begin
          idx_r <= idx_r + 1'b1;
          if (idx_last) begin
            n_r     <= '0;
            stage_r <= '0;
            state_r <= ST_BF_RD;
          end else begin
            state_r <= ST_BR;
          end
        end
        ST_BF_RD:  state_r <= ST_BF_MUL;
        ST_BF_MUL: state_r <= ST_BF_ADD;
        ST_BF_ADD: state_r <= ST_BF_WA;
        ST_BF_WA:  state_r <= ST_BF_WB;
        ST_BF_WB: begin
          n_r <= n_r + 1'b1;
          if (&n_r && stage_r == STG_W'(LOG2_PTS - 1)) begin
            idx_r   <= '0;
            state_r <= ST_MG_RD;
          end else begin
            state_r <= ST_BF_RD;
            if (&n_r) begin
              stage_r <= stage_r + 1'b1;
            end
          end
        end
        ST_MG_RD: state_r <= ST_MG_SQ;
        ST_MG_SQ: state_r <= ST_MG_ST;
        ST_MG_ST: state_r <= ST_MG_WT;
        ST_MG_WT: begin
          if (sts.sqrt_done) begin
            idx_r <= idx_r + 1'b1;
            if (idx_last) begin
              have_res_r <= 1'b1;
              state_r    <= ST_IDLE;
            end else begin
              state_r <= ST_MG_RD;
            end
          end
        end
        ST_RD_WT: state_r <= ST_RD_OUT;
        ST_RD_OUT: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/fft_magnitude_spectrum_unit.sv -----
// top level of the 512-point fft magnitude spectrum unit
// A load transaction writes its sample in the cycle it is accepted. The
// transaction carrying the last sample of a frame starts a transform on a
// single butterfly unit over one dual-read sample memory, during which no
// input is accepted: a bit-reversal sweep swapping bit-reversed pairs, then
// (POINTS/2) * log2(POINTS) butterflies, each through read, multiply, add
// and the two writes, then a magnitude pass on the one-bit-per-cycle square
// root unit for every bin. A read transaction returns its result through a
// read register and the output register, and reports zero with ready_res low
// until the first transform has finished.
module fft_magnitude_spectrum_unit (
  input  logic        clk,
  input  logic        rst_n,
  fftm_in_if.sink     in_if,
  fftm_out_if.source  out_if
);
  import fftm_pkg::*;

  fftm_cmd_t cmd;
  fftm_sts_t sts;

  fftm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_action (in_if.action),
    .in_ready  (in_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fftm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (in_if.sample),
    .bin       (in_if.bin),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .magnitude (out_if.magnitude),
    .ready_res (out_if.ready_res)
  );

  // a bin is only written when the root is final
  a_mag_we_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mag_we |-> sts.sqrt_done)
    else $error("magnitude written before square root finished");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready_res |-> out_if.magnitude == '0)
    else $error("nonzero magnitude before first transform");

  a_ready_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && out_if.ready_res |=>
      !(out_if.valid && !out_if.ready_res))
    else $error("ready flag dropped after a transform");

  // loads and reads are never accepted while a transform runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en || cmd.sqrt_start |-> !in_if.ready)
    else $error("input accepted during transform");

endmodule

// ----- verif/fftm_checker.sv -----
// transaction monitor, fft magnitude predictor and result comparison for the spectrum unit
`timescale 1ns / 1ps
module fftm_checker (
  input  logic  clk,
  input  logic  rst_n,
  fftm_in_if    in_mon,
  fftm_out_if   out_mon,
  output int    fail_count,
  output int    pending
);
  import fftm_pkg::*;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic             ready_res;
  } spectrum_read_t;

  localparam int  TW_FRAC = TW_BITS - 1;
  localparam longint unsigned PI_FIX = 64'd3373259426;

  longint          sample_re [POINTS];
  longint          sample_im [POINTS];
  logic [MAG_W-1:0] bin_mag [POINTS];
  longint          tw_cos [HALF];
  longint          tw_sin [HALF];
  int              fill_idx;
  logic            spectrum_valid;
  spectrum_read_t  read_queue[$];

  function automatic longint to_q15(input longint v);
    longint unsigned m, r;
    m = (v < 0) ? -v : v;
    r = ((m << TW_FRAC) + (64'd1 << 29)) >> 30;
    if (r > (64'd1 << TW_FRAC) - 1) begin
      r = (64'd1 << TW_FRAC) - 1;
    end
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // q30 taylor series for cos and sin, quantized to q1.15
  task automatic make_twiddles();
    longint unsigned ang, sq, cterm, sterm, num;
    longint          csum, ssum;
    logic            mirror;
    for (int t = 0; t < HALF; t++) begin
      mirror = (4 * t > POINTS);
      num    = mirror ? POINTS - 2 * t : 2 * t;
      ang    = (PI_FIX * num) / POINTS;
      sq     = (ang * ang) >> 30;
      cterm  = 64'd1 << 30;
      sterm  = ang;
      csum   = cterm;
      ssum   = sterm;
      for (int k = 1; k <= 12; k++) begin
        cterm = ((cterm * sq) >> 30) / ((2 * k - 1) * (2 * k));
        sterm = ((sterm * sq) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          csum -= cterm;
          ssum -= sterm;
        end else begin
          csum += cterm;
          ssum += sterm;
        end
      end
      tw_cos[t] = to_q15(mirror ? -csum : csum);
      tw_sin[t] = to_q15(ssum);
    end
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic compute_spectrum();
    int              rev, i2, w;
    longint          c, s, br, bi, tr, ti, ur, ui, tmp;
    longint unsigned mag;
    for (int i = 0; i < POINTS; i++) begin
      rev = 0;
      for (int b = 0; b < LOG2_PTS; b++) rev = (rev << 1) | ((i >> b) & 1);
      if (rev > i) begin
        tmp = sample_re[i]; sample_re[i] = sample_re[rev]; sample_re[rev] = tmp;
        tmp = sample_im[i]; sample_im[i] = sample_im[rev]; sample_im[rev] = tmp;
      end
    end
    for (int m = 2; m <= POINTS; m <<= 1) begin
      for (int k = 0; k < POINTS; k += m) begin
        for (int j = 0; j < m / 2; j++) begin
          i2 = k + j + m / 2;
          w  = j * (POINTS / m);
          c  = tw_cos[w];
          s  = tw_sin[w];
          br = sample_re[i2];
          bi = sample_im[i2];
          tr = (c * br + s * bi + (64'sd1 <<< (TW_FRAC - 1))) >>> TW_FRAC;
          ti = (c * bi - s * br + (64'sd1 <<< (TW_FRAC - 1))) >>> TW_FRAC;
          ur = sample_re[k + j];
          ui = sample_im[k + j];
          sample_re[k + j] = ur + tr;
          sample_im[k + j] = ui + ti;
          sample_re[i2]    = ur - tr;
          sample_im[i2]    = ui - ti;
        end
      end
    end
    for (int i = 0; i < POINTS; i++) begin
      br  = sample_re[i] < 0 ? -sample_re[i] : sample_re[i];
      bi  = sample_im[i] < 0 ? -sample_im[i] : sample_im[i];
      mag = int_sqrt(br * br + bi * bi);
      bin_mag[i] = (mag > (64'd1 << MAG_W) - 1) ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
    end
  endtask

  initial begin
    make_twiddles();
    fail_count     = 0;
    fill_idx       = 0;
    spectrum_valid = 1'b0;
  end

  assign pending = read_queue.size();

  always @(posedge clk) begin
    spectrum_read_t exp_rd;
    if (rst_n && in_mon.valid && in_mon.ready) begin
      if (in_mon.action == ACT_LOAD) begin
        sample_re[fill_idx] = longint'(in_mon.sample);
        sample_im[fill_idx] = 0;
        fill_idx++;
        if (fill_idx == POINTS) begin
          compute_spectrum();
          spectrum_valid = 1'b1;
          fill_idx       = 0;
        end
      end else begin
        exp_rd.magnitude = spectrum_valid ? bin_mag[in_mon.bin] : '0;
        exp_rd.ready_res = spectrum_valid;
        read_queue.push_back(exp_rd);
      end
    end
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (read_queue.size() == 0) begin
        $display("%0t: unexpected result magnitude %0d ready_res %0b", $time,
                 out_mon.magnitude, out_mon.ready_res);
        fail_count++;
      end else begin
        exp_rd = read_queue.pop_front();
        if (out_mon.magnitude !== exp_rd.magnitude) begin
          $display("%0t: magnitude expected %0d got %0d", $time, exp_rd.magnitude,
                   out_mon.magnitude);
          fail_count++;
        end
        if (out_mon.ready_res !== exp_rd.ready_res) begin
          $display("%0t: ready_res expected %0b got %0b", $time, exp_rd.ready_res,
                   out_mon.ready_res);
          fail_count++;
        end
      end
    end
  end

endmodule

// ----- verif/tb_fft_magnitude_spectrum_unit.sv -----
// stimulus, clock, reset and verdict for the fft magnitude spectrum unit
`timescale 1ns / 1ps
module tb_fft_magnitude_spectrum_unit;
  import fftm_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  logic idle_on;
  logic hold_long;

  fftm_in_if  in_if ();
  fftm_out_if out_if ();

  fft_magnitude_spectrum_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  fftm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one transaction on the input channel, with an optional idle burst first
  task automatic send(input logic act, input logic signed [SAMPLE_W-1:0] smp,
                      input logic [BIN_W-1:0] bn);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.sample <= smp;
    in_if.bin    <= bn;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // part of a frame of loads, with reads mixed in
  task automatic load_frame(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        send(ACT_READ, '0, BIN_W'($urandom));
      end
      send(ACT_LOAD, SAMPLE_W'($urandom), '0);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 17);
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    cycles       = 0;
    idle_on      = 1'b0;
    hold_long    = 1'b0;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.action <= ACT_LOAD;
    in_if.sample <= '0;
    in_if.bin    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads before any transform has completed
    send(ACT_READ, '0, 9'd0);
    send(ACT_READ, '0, 9'd511);
    send(ACT_READ, '0, 9'h155);
    send(ACT_READ, '0, 9'h0aa);
    // full-scale, small and alternating-bit samples at the start of the first frame
    send(ACT_LOAD, 16'sh7fff, '0);
    send(ACT_LOAD, 16'sh8000, '0);
    send(ACT_LOAD, 16'sh0001, '0);
    send(ACT_LOAD, 16'shffff, '0);
    send(ACT_LOAD, 16'sh5555, '0);
    send(ACT_LOAD, 16'sh2aaa, '0);

    idle_on = 1'b1;
    for (int n = 6; n < POINTS; n++) begin
      if ($urandom_range(0, 11) == 0) send(ACT_READ, '0, BIN_W'($urandom));
      send(ACT_LOAD, pick_sample(), '0);
    end

    // first spectrum: edge and middle bins, then reads against a stalled receiver
    send(ACT_READ, '0, 9'd0);
    send(ACT_READ, '0, 9'd256);
    send(ACT_READ, '0, 9'd511);
    hold_long = 1'b1;
    for (int n = 0; n < 40; n++) send(ACT_READ, '0, BIN_W'($urandom));

    // start of a second frame, reads return the first spectrum meanwhile
    load_frame(80);

    // last part without idling
    idle_on = 1'b0;
    for (int n = 0; n < 40; n++) send(ACT_READ, '0, BIN_W'($urandom));
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fftm_pkg.sv
design/fftm_if.sv
design/fftm_isqrt.sv
design/fftm_datapath.sv
design/fftm_ctrl.sv
design/fft_magnitude_spectrum_unit.sv
verif/fftm_checker.sv
verif/tb_fft_magnitude_spectrum_unit.sv
